>>> rtl/core/fskid_pkg.sv
// Shared types, constants and helper functions for the FSK callsign ID framer.
// Used by every module under rtl/core; depends on nothing else.
`timescale 1ns / 1ps

package fskid_pkg;

    typedef enum logic [1:0] {
        OP_BEGIN = 2'd0,
        OP_CHAR  = 2'd1,
        OP_END   = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CMD_CHAR      = 2'd0,
        CMD_LEAD_CHAR = 2'd1,
        CMD_END       = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [5:0]  code;
    } cmd_t;

    typedef struct packed {
        logic [11:0] one_hz;
        logic [11:0] zero_hz;
        logic [7:0]  bit_ms;
    } cfg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef enum logic [1:0] {
        REG_ONE_TONE  = 2'd0,
        REG_ZERO_TONE = 2'd1,
        REG_BIT_TIME  = 2'd2,
        REG_SPARE     = 2'd3
    } reg_index_t;

    localparam logic [5:0]  HEADER_CODE = 6'h2A;
    localparam logic [5:0]  END_CODE    = 6'h01;
    localparam logic [5:0]  CHAR_OFFSET = 6'h20;

    localparam logic [11:0] HZ_1500     = 12'd1500;
    localparam logic [11:0] HZ_1900     = 12'd1900;
    localparam logic [11:0] HZ_2100     = 12'd2100;
    localparam logic [9:0]  MS_300      = 10'd300;
    localparam logic [9:0]  MS_100      = 10'd100;

    localparam logic [11:0] RST_ONE_HZ  = 12'd1900;
    localparam logic [11:0] RST_ZERO_HZ = 12'd2100;
    localparam logic [7:0]  RST_BIT_MS  = 8'd22;

    localparam logic [3:0]  LEAD_LAST   = 4'd14;
    localparam logic [3:0]  CHAR_LAST   = 4'd5;
    localparam logic [3:0]  END_LAST    = 4'd12;
    localparam logic [3:0]  LEAD_HDR    = 4'd3;
    localparam logic [3:0]  LEAD_CODE   = 4'd9;
    localparam logic [3:0]  END_CHK     = 4'd6;

    function automatic logic [7:0] upper_latin1(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h61 && c <= 8'h7A) begin
            r = c - 8'h20;
        end else if (c >= 8'hE0 && c <= 8'hFE && c != 8'hF7) begin
            r = c - 8'h20;
        end
        return r;
    endfunction

endpackage

>>> rtl/core/fskid_front.sv
// Front end: accepts input words, keeps the frame state and checksum, and turns
// character words and the end word of a non-empty frame into tone commands. Depends on fskid_pkg.
`timescale 1ns / 1ps

module fskid_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [1:0]            s_op,
    input  logic [7:0]            s_char,
    input  fskid_pkg::q_status_t  q_status,
    output logic                  q_push,
    output fskid_pkg::cmd_t       q_cmd
);

    logic       has_chars_reg;
    logic       has_chars_next;
    logic [5:0] checksum_reg;
    logic [5:0] checksum_next;
    logic       accept;
    logic       want_push;
    logic [7:0] upper;
    logic [5:0] code;

    assign s_tready = ~q_status.full;
    assign accept   = s_tvalid & s_tready;

    always_comb begin
        upper          = fskid_pkg::upper_latin1(s_char);
        code           = upper[5:0] - fskid_pkg::CHAR_OFFSET;
        has_chars_next = has_chars_reg;
        checksum_next  = checksum_reg;
        want_push      = 1'b0;
        q_cmd.kind     = fskid_pkg::CMD_CHAR;
        q_cmd.code     = code;
        unique case (fskid_pkg::op_t'(s_op))
            fskid_pkg::OP_BEGIN: begin
                has_chars_next = 1'b0;
                checksum_next  = '0;
            end
            fskid_pkg::OP_CHAR: begin
                want_push      = 1'b1;
                q_cmd.kind     = has_chars_reg ? fskid_pkg::CMD_CHAR
                                               : fskid_pkg::CMD_LEAD_CHAR;
                checksum_next  = has_chars_reg ? (checksum_reg ^ code) : code;
                has_chars_next = 1'b1;
            end
            fskid_pkg::OP_END: begin
                want_push      = has_chars_reg;
                q_cmd.kind     = fskid_pkg::CMD_END;
                q_cmd.code     = checksum_reg;
                has_chars_next = 1'b0;
                checksum_next  = '0;
            end
            default: begin
            end
        endcase
    end

    assign q_push = accept & want_push;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            has_chars_reg <= 1'b0;
            checksum_reg  <= '0;
        end else if (accept) begin
            has_chars_reg <= has_chars_next;
            checksum_reg  <= checksum_next;
        end
    end

endmodule

>>> rtl/core/fskid_queue.sv
// Two-entry command queue between front and back end.
// Depends on fskid_pkg.
`timescale 1ns / 1ps

module fskid_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  fskid_pkg::cmd_t       push_cmd,
    input  logic                  pop,
    output fskid_pkg::cmd_t       head,
    output fskid_pkg::q_status_t  status
);

    fskid_pkg::cmd_t mem_reg [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      count_reg;
    logic [1:0]      count_next;

    assign head         = mem_reg[rd_ptr_reg];
    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

>>> rtl/core/fskid_back.sv
// Back end: steps through the tones of the head command, one per cycle while the
// output is not stalled, into a registered output stage. Depends on fskid_pkg.
`timescale 1ns / 1ps

module fskid_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  fskid_pkg::cfg_t       cfg,
    input  fskid_pkg::cmd_t       head,
    input  fskid_pkg::q_status_t  q_status,
    output logic                  pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [23:0]           m_tdata,
    output logic                  m_tlast
);

    logic [3:0]  step_reg;
    logic [3:0]  step_next;
    logic        m_tvalid_reg;
    logic        m_tvalid_next;
    logic [11:0] tone_hz_reg;
    logic [9:0]  duration_ms_reg;
    logic        last_reg;
    logic        load;
    logic        last;
    logic        bit_val;
    logic        fixed;
    logic [11:0] fixed_hz;
    logic [9:0]  fixed_ms;
    logic [11:0] tone_hz;
    logic [9:0]  duration_ms;
    logic [3:0]  hdr_idx;
    logic [3:0]  code_idx;
    logic [3:0]  chk_idx;

    assign load = ~q_status.empty & (~m_tvalid_reg | m_tready);

    always_comb begin
        hdr_idx  = step_reg - fskid_pkg::LEAD_HDR;
        code_idx = step_reg - fskid_pkg::LEAD_CODE;
        chk_idx  = step_reg - fskid_pkg::END_CHK;
        fixed    = 1'b0;
        fixed_hz = fskid_pkg::HZ_1900;
        fixed_ms = fskid_pkg::MS_100;
        bit_val  = 1'b0;
        last     = 1'b0;
        unique case (head.kind)
            fskid_pkg::CMD_LEAD_CHAR: begin
                last = (step_reg == fskid_pkg::LEAD_LAST);
                if (step_reg == 4'd0) begin
                    fixed    = 1'b1;
                    fixed_hz = fskid_pkg::HZ_1500;
                    fixed_ms = fskid_pkg::MS_300;
                end else if (step_reg == 4'd1) begin
                    fixed    = 1'b1;
                    fixed_hz = fskid_pkg::HZ_2100;
                end else if (step_reg == 4'd2) begin
                    fixed    = 1'b1;
                    fixed_ms = {2'b00, cfg.bit_ms};
                end else if (step_reg < fskid_pkg::LEAD_CODE) begin
                    bit_val = fskid_pkg::HEADER_CODE[hdr_idx[2:0]];
                end else begin
                    bit_val = head.code[code_idx[2:0]];
                end
            end
            fskid_pkg::CMD_CHAR: begin
                last    = (step_reg == fskid_pkg::CHAR_LAST);
                bit_val = head.code[step_reg[2:0]];
            end
            fskid_pkg::CMD_END: begin
                last = (step_reg == fskid_pkg::END_LAST);
                if (step_reg < fskid_pkg::END_CHK) begin
                    bit_val = fskid_pkg::END_CODE[step_reg[2:0]];
                end else if (step_reg < fskid_pkg::END_LAST) begin
                    bit_val = head.code[chk_idx[2:0]];
                end else begin
                    fixed = 1'b1;
                end
            end
            default: begin
                last = 1'b1;
            end
        endcase
        tone_hz     = fixed ? fixed_hz : (bit_val ? cfg.one_hz : cfg.zero_hz);
        duration_ms = fixed ? fixed_ms : {2'b00, cfg.bit_ms};
    end

    assign pop           = load & last;
    assign step_next     = load ? (last ? 4'd0 : step_reg + 4'd1) : step_reg;
    assign m_tvalid_next = load | (m_tvalid_reg & ~m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            step_reg     <= step_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            tone_hz_reg     <= tone_hz;
            duration_ms_reg <= duration_ms;
            last_reg        <= last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, duration_ms_reg, tone_hz_reg};
    assign m_tlast  = last_reg;

endmodule

>>> rtl/core/fsk_callsign_id_framer_top.sv
// FSK callsign identification framer, top level: register file, front end,
// command queue and tone sequencer. Depends on fskid_pkg and rtl/core modules.
`timescale 1ns / 1ps

// Input words carry an operation in s_tuser (begin, character, end) and a
// Latin-1 character in s_tdata; each result word is one tone (frequency and
// duration) with m_tlast on the final tone caused by an input word. The tone
// sequencer emits one tone per cycle when not stalled; a character word gives 6
// tones, the first character of a frame 15 (leader, header code, character) and
// a closing end word 13; begin words and the end word of an empty frame produce
// no tone. The front end runs ahead of the sequencer by up to two queued words,
// and the sequencer holds while a tone waits on m_tready behind the registered
// output stage. Registers are written over the cfg port (index 0 one
// tone, 1 zero tone, 2 bit time in ms) and must only change while idle.
module fsk_callsign_id_framer_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic [1:0]  s_tuser,   // [1:0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [11:0] tone_hz, [21:12] duration_ms, [23:22] zero
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data
);

    fskid_pkg::cfg_t       cfg_reg;
    fskid_pkg::cmd_t       push_cmd;
    fskid_pkg::cmd_t       head;
    fskid_pkg::q_status_t  q_status;
    logic                  q_push;
    logic                  q_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.one_hz  <= fskid_pkg::RST_ONE_HZ;
            cfg_reg.zero_hz <= fskid_pkg::RST_ZERO_HZ;
            cfg_reg.bit_ms  <= fskid_pkg::RST_BIT_MS;
        end else if (cfg_valid && cfg_ready) begin
            unique case (fskid_pkg::reg_index_t'(cfg_index))
                fskid_pkg::REG_ONE_TONE:  cfg_reg.one_hz  <= cfg_data;
                fskid_pkg::REG_ZERO_TONE: cfg_reg.zero_hz <= cfg_data;
                fskid_pkg::REG_BIT_TIME:  cfg_reg.bit_ms  <= cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    fskid_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_op     (s_tuser),
        .s_char   (s_tdata),
        .q_status (q_status),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    fskid_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .head     (head),
        .status   (q_status)
    );

    fskid_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .head     (head),
        .q_status (q_status),
        .pop      (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

`ifndef SYNTH
    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_status.full)
        else $error("command pushed into full queue");

    a_no_pop_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_status.empty)
        else $error("command popped from empty queue");

    a_pop_marks_last: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> (m_tvalid && m_tlast))
        else $error("command retired without a final tone on the output");
`endif

endmodule
